// ===== hdl/axis_dead_zone_rescale_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef AXIS_DEAD_ZONE_RESCALE_ASSERT_SVH
`define AXIS_DEAD_ZONE_RESCALE_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define ADZR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define ADZR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/adzr_pkg.sv =====
`default_nettype none
package adzr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DZ_BITS     = 15;
  localparam int FS_BITS     = 16;
  localparam int QUO_BITS    = 15;
  localparam int OUT_BITS    = QUO_BITS + 1;
  localparam int NUM_BITS    = QUO_BITS + FS_BITS;
  localparam int CMP_BITS    = (SAMPLE_BITS > FS_BITS) ? SAMPLE_BITS : FS_BITS;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [QUO_BITS-1:0] OUT_MAX = {QUO_BITS{1'b1}};
  localparam logic [DZ_BITS-1:0]  DZ_RESET = '0;
  localparam logic [FS_BITS-1:0]  FS_RESET = FS_BITS'(32768);

  localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_ZONE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FULL_SCALE = CFG_IDX_BITS'(1);

  // Word handed from cell to cell: remainder and the shared
  // numerator/quotient register of the restoring divider.
  typedef struct packed {
    logic                neg;
    logic                sat;
    logic [FS_BITS-1:0]  rem;
    logic [QUO_BITS-1:0] acc;
  } adzr_word_t;

endpackage
`default_nettype wire

// ===== hdl/adzr_in_if.sv =====
`default_nettype none
interface adzr_in_if;
  import adzr_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] raw_value;
  modport source (output valid, output raw_value, input ready);
  modport sink (input valid, input raw_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/adzr_out_if.sv =====
`default_nettype none
interface adzr_out_if;
  import adzr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] scaled_value;
  modport source (output valid, output scaled_value, input ready);
  modport sink (input valid, input scaled_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/adzr_cfg_if.sv =====
`default_nettype none
interface adzr_cfg_if;
  import adzr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/adzr_prep.sv =====
`default_nettype none
module adzr_prep (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [adzr_pkg::DZ_BITS-1:0]           dead_zone,
  input  wire logic [adzr_pkg::FS_BITS-1:0]           full_scale,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [adzr_pkg::SAMPLE_BITS-1:0] raw_value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output adzr_pkg::adzr_word_t                        out_data
);
  import adzr_pkg::*;

  logic [SAMPLE_BITS-1:0] mag;
  logic [CMP_BITS-1:0]    mag_c;
  logic [CMP_BITS-1:0]    dz_c;
  logic [CMP_BITS-1:0]    ex_full;
  logic [FS_BITS-1:0]     span;
  logic [FS_BITS-1:0]     ex;
  logic [NUM_BITS-1:0]    num;
  logic                   neg;
  logic                   in_zone;
  logic                   degenerate;
  adzr_word_t             word_next;

  assign neg  = raw_value[SAMPLE_BITS-1];
  // The most negative sample negates to itself, which read unsigned is its magnitude.
  assign mag  = neg ? (~raw_value + 1'b1) : raw_value;
  assign mag_c = CMP_BITS'(mag);
  assign dz_c  = CMP_BITS'(dead_zone);
  assign in_zone    = mag_c <= dz_c;
  assign degenerate = full_scale <= {1'b0, dead_zone};
  assign span    = full_scale - {1'b0, dead_zone};
  assign ex_full = mag_c - dz_c;
  assign ex      = (ex_full > CMP_BITS'(span)) ? span : ex_full[FS_BITS-1:0];
  assign num     = (in_zone || degenerate) ? '0 : NUM_BITS'(ex) * NUM_BITS'(OUT_MAX);

  always_comb begin
    word_next.neg = neg;
    word_next.sat = degenerate && !in_zone;
    word_next.rem = num[NUM_BITS-1:QUO_BITS];
    word_next.acc = num[QUO_BITS-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= word_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/adzr_div_cell.sv =====
`default_nettype none
module adzr_div_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [adzr_pkg::FS_BITS-1:0] span,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire adzr_pkg::adzr_word_t         in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output adzr_pkg::adzr_word_t              out_data
);
  import adzr_pkg::*;

  logic [FS_BITS:0] trial;
  logic [FS_BITS:0] diff;
  logic             ge;
  adzr_word_t       word_next;

  // One restoring step: shift in the next numerator bit, subtract if it fits,
  // and shift the quotient bit into the bottom of the same register.
  assign trial = {in_data.rem, in_data.acc[QUO_BITS-1]};
  assign diff  = trial - {1'b0, span};
  // A zero span only comes with a degenerate scale, where samples inside the
  // dead zone still need a zero quotient.
  assign ge    = (span != '0) && (trial >= {1'b0, span});

  always_comb begin
    word_next.neg = in_data.neg;
    word_next.sat = in_data.sat;
    word_next.rem = ge ? diff[FS_BITS-1:0] : trial[FS_BITS-1:0];
    word_next.acc = {in_data.acc[QUO_BITS-2:0], ge};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= word_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/axis_dead_zone_rescale.sv =====
// Dead-zone rescaler for one signed axis stream. A sample whose magnitude is
// at or below dead_zone gives 0; otherwise the result is the sign of the
// sample times 32767*min(|v|-dead_zone, full_scale-dead_zone)/(full_scale-dead_zone),
// truncated toward zero, so it saturates at +/-32767. If full_scale is not above
// dead_zone, any sample outside the dead zone gives +/-32767. Register 0 is
// dead_zone (15 bits), register 1 is full_scale (16 bits); other indexes are
// ignored, and registers may only be written while no beat is in flight.
// Throughput is one beat per cycle while the output is not stalled; each input
// beat passes through one operand stage (magnitude, clamp, 16x15 multiply)
// followed by a chain of 15 divider cells, each a 17-bit compare-subtract
// producing one quotient bit. Every stage has its own valid and ready, so empty
// stages fill while a result waits at the output.
`default_nettype none
module axis_dead_zone_rescale (
  input  wire logic clk,
  input  wire logic rst,
  adzr_cfg_if.sink  cfg,
  adzr_in_if.sink   sample,
  adzr_out_if.source result
);
  import adzr_pkg::*;

  logic [DZ_BITS-1:0] dead_zone;
  logic [FS_BITS-1:0] full_scale;
  logic [FS_BITS-1:0] span;

  logic       stage_valid [0:QUO_BITS];
  logic       stage_ready [0:QUO_BITS];
  adzr_word_t stage_data  [0:QUO_BITS];

  logic [QUO_BITS-1:0] mag_out;
  logic [OUT_BITS-1:0] val_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone  <= DZ_RESET;
      full_scale <= FS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEAD_ZONE:  dead_zone  <= cfg.data[DZ_BITS-1:0];
        REG_FULL_SCALE: full_scale <= cfg.data[FS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign span = full_scale - {1'b0, dead_zone};

  adzr_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .dead_zone  (dead_zone),
    .full_scale (full_scale),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .raw_value  (sample.raw_value),
    .out_valid  (stage_valid[0]),
    .out_ready  (stage_ready[0]),
    .out_data   (stage_data[0])
  );

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    adzr_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .span      (span),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  assign stage_ready[QUO_BITS] = result.ready;
  assign result.valid = stage_valid[QUO_BITS];

  // After the last cell the accumulator holds the full quotient.
  assign mag_out = stage_data[QUO_BITS].sat ? OUT_MAX : stage_data[QUO_BITS].acc;
  assign val_out = {1'b0, mag_out};
  assign result.scaled_value = stage_data[QUO_BITS].neg ? (~val_out + 1'b1) : val_out;

endmodule
`default_nettype wire

// ===== hdl/adzr_checker.sv =====
`default_nettype none
`include "axis_dead_zone_rescale_assert.svh"
module adzr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            sample_ready,
  input wire logic                            result_valid,
  input wire logic                            result_ready,
  input wire logic [adzr_pkg::OUT_BITS-1:0]   scaled_value
);
  import adzr_pkg::*;

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // A stalled result beat keeps its valid and its value.
  `ADZR_ASSERT_NEXT(a_stall_valid, result_valid && !result_ready, result_valid)
  `ADZR_ASSERT_NEXT(a_stall_data, result_valid && !result_ready, $stable(scaled_value))

  // Reset empties the whole chain.
  `ADZR_ASSERT_NOW(a_reset_empty, $past(rst), !result_valid)

  // Output saturates symmetrically, never at the most negative code.
  `ADZR_ASSERT_NOW(a_no_most_neg, result_valid, scaled_value != MOST_NEG)

  // With the output stage empty every stage can move, so a new sample is taken.
  `ADZR_ASSERT_NOW(a_ready_when_drained, !result_valid, sample_ready)

endmodule

bind axis_dead_zone_rescale adzr_checker u_adzr_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .scaled_value (result.scaled_value)
);
`default_nettype wire
